FILE: src/cpsg_pkg.sv
// Shared types and codes of the convex polygon span generator.
`default_nettype none

package cpsg_pkg;

    // Walk phase of the vertex list
    typedef enum logic [1:0] {
        PH_OPEN = 2'd0,
        PH_WALK = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    // Status of the bit-serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

FILE: src/cpsg_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module cpsg_div #(
    parameter int W = 17
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [W-1:0]     dividend,
    input  wire logic [W-1:0]     divisor,
    output cpsg_pkg::div_stat_t   stat,
    output logic [W-1:0]          quotient,
    output logic [W-1:0]          remainder
);
    import cpsg_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;

    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          fits;

    // One trial subtraction per cycle
    always_comb begin
        shifted  = {rem_reg, quo_reg[W-1]};
        fits     = shifted >= {1'b0, dvs_reg};
        diff     = shifted - {1'b0, dvs_reg};
        rem_next = fits ? diff[W-1:0] : shifted[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= CW'(W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: src/convex_polygon_span_generator.sv
// Convex polygon span generator: vertex memory, edge walker and span output.
// A closing vertex load of n >= 3 vertices starts the top-vertex scan through the
//   vertex memory and the edge setup.
// A span item for which an edge needs a division waits on the bit-serial divider
//   (COORD_BITS+1 quotient bits).
// One item is worked on at a time; a finished span waits in the output register.
// Reset (aresetn low, synchronous) empties the vertex list and the output register.
`default_nettype none

module convex_polygon_span_generator #(
    parameter int MAX_CORNERS = 16,
    parameter int COORD_BITS  = 16,
    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((3 * COORD_BITS + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [IN_W-1:0]  s_axis_tdata,   // vertex_x, vertex_y, zero pad
    input  wire logic             s_axis_tlast,   // last_vertex
    input  wire logic             s_axis_tuser,   // cmd
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // span_y, span_left, span_right, zero pad
    output logic                  m_axis_tlast,   // last_span
    output logic                  m_axis_tuser    // empty_res
);
    import cpsg_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int AW   = $clog2(MAX_CORNERS);
    localparam int NW   = $clog2(MAX_CORNERS + 1);
    localparam int DW   = CB + 1;

    localparam logic signed [CB+2:0] SAT_HI = {4'b0000, {(CB-1){1'b1}}};
    localparam logic signed [CB+2:0] SAT_LO = {4'b1111, {(CB-1){1'b0}}};

    // Sequencer states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_SCAN  = 11'b000_0000_0010,
        ST_INIT0 = 11'b000_0000_0100,
        ST_INIT1 = 11'b000_0000_1000,
        ST_INIT2 = 11'b000_0001_0000,
        ST_CHECK = 11'b000_0010_0000,
        ST_FETCH = 11'b000_0100_0000,
        ST_ACCUM = 11'b000_1000_0000,
        ST_DIV   = 11'b001_0000_0000,
        ST_MOVE  = 11'b010_0000_0000,
        ST_EMIT  = 11'b100_0000_0000
    } state_t;

    // State of one walking edge
    typedef struct packed {
        logic [AW-1:0]        idx;
        logic signed [CB-1:0] tx;
        logic signed [CB-1:0] ty;
        logic [CB-1:0]        run;
        logic [CB-1:0]        rise;
        logic signed [1:0]    dirx;
        logic signed [1:0]    diry;
        logic signed [CB+1:0] err;
        logic signed [CB-1:0] px;
        logic signed [CB-1:0] py;
    } walker_t;

    // Aim an edge from (fx, fy) at the vertex word tgt = {y, x}
    function automatic walker_t aim(input logic [AW-1:0] idx,
                                    input logic signed [CB-1:0] fx,
                                    input logic signed [CB-1:0] fy,
                                    input logic [2*CB-1:0] tgt);
        walker_t w;
        logic signed [CB:0] dx;
        logic signed [CB:0] dy;
        logic signed [CB:0] ndx;
        logic signed [CB:0] ndy;
        w.idx  = idx;
        w.tx   = tgt[CB-1:0];
        w.ty   = tgt[2*CB-1:CB];
        dx     = {w.tx[CB-1], w.tx} - {fx[CB-1], fx};
        dy     = {w.ty[CB-1], w.ty} - {fy[CB-1], fy};
        ndx    = -dx;
        ndy    = -dy;
        w.run  = dx[CB] ? ndx[CB-1:0] : dx[CB-1:0];
        w.rise = dy[CB] ? ndy[CB-1:0] : dy[CB-1:0];
        w.dirx = dx[CB] ? 2'sb11 : ((dx != '0) ? 2'sb01 : 2'sb00);
        w.diry = dy[CB] ? 2'sb11 : ((dy != '0) ? 2'sb01 : 2'sb00);
        w.err  = {3'b000, w.rise[CB-1:1]};
        w.px   = fx;
        w.py   = fy;
        return w;
    endfunction

    // Clamp to the signed coordinate range
    function automatic logic signed [CB-1:0] clamp(input logic signed [CB+2:0] v);
        logic signed [CB+2:0] c;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end else begin
            c = v;
        end
        return c[CB-1:0];
    endfunction

    // Neighbor of a vertex in the ring, forward or backward
    function automatic logic [AW-1:0] ring_next(input logic back,
                                                input logic [AW-1:0] idx,
                                                input logic [NW-1:0] cnt);
        logic [NW-1:0] inc;
        logic [NW-1:0] last;
        logic [AW-1:0] r;
        inc  = NW'(idx) + NW'(1);
        last = cnt - NW'(1);
        if (!back) begin
            r = (inc >= cnt) ? '0 : inc[AW-1:0];
        end else begin
            r = (idx == '0) ? last[AW-1:0] : idx - AW'(1);
        end
        return r;
    endfunction

    // Registers
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [NW-1:0]        count_reg, count_next;
    logic [NW-1:0]        scan_idx_reg, scan_idx_next;
    logic                 rd_vld_reg, rd_vld_next;
    logic [AW-1:0]        top_idx_reg, top_idx_next;
    logic signed [CB-1:0] min_x_reg, min_x_next;
    logic signed [CB-1:0] min_y_reg, min_y_next;
    walker_t              wlk_reg [2];
    walker_t              wlk_next [2];
    logic                 edge_sel_reg, edge_sel_next;
    logic                 done_reg, done_next;
    logic [CB:0]          cnt_reg, cnt_next;
    logic signed [CB-1:0] sp_y_reg, sp_y_next;
    logic signed [CB-1:0] sp_l_reg, sp_l_next;
    logic signed [CB-1:0] sp_r_reg, sp_r_next;
    logic                 sp_empty_reg, sp_empty_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [CB-1:0] out_y_reg, out_l_reg, out_r_reg;
    logic                 out_last_reg, out_empty_reg;
    logic                 out_load;

    // Vertex memory, word = {y, x}
    logic [2*CB-1:0]      mem [MAX_CORNERS];
    logic [2*CB-1:0]      rd_data_reg;
    logic [AW-1:0]        rd_addr;
    logic [AW-1:0]        wr_addr;
    logic [2*CB-1:0]      wr_data;
    logic                 mem_we;

    // Working signals
    logic                 accept;
    logic                 is_span;
    logic signed [CB-1:0] in_x, in_y;
    logic [NW-1:0]        cnt_base;
    logic                 room;
    walker_t              cur;
    walker_t              upd;
    logic [AW-1:0]        nx_idx;
    logic [AW-1:0]        top_fwd, top_bwd;
    logic signed [CB+1:0] sum;
    logic signed [CB+1:0] sum_inc;
    logic                 div_start;
    logic [DW-1:0]        div_quo, div_rem;
    div_stat_t            div_stat;
    logic signed [CB+2:0] mx, my;
    logic signed [CB-1:0] rd_y;

    assign accept  = s_axis_tvalid && s_axis_tready;
    assign is_span = s_axis_tuser;
    assign in_x    = s_axis_tdata[CB-1:0];
    assign in_y    = s_axis_tdata[2*CB-1:CB];
    assign s_axis_tready = (state_reg == ST_IDLE);

    assign cnt_base = (phase_reg != PH_OPEN) ? '0 : count_reg;
    assign room     = cnt_base < NW'(MAX_CORNERS);
    assign mem_we   = accept && !is_span && room;
    assign wr_addr  = cnt_base[AW-1:0];
    assign wr_data  = {in_y, in_x};

    assign cur     = edge_sel_reg ? wlk_reg[1] : wlk_reg[0];
    assign nx_idx  = ring_next(edge_sel_reg, cur.idx, count_reg);
    assign top_fwd = ring_next(1'b0, top_idx_reg, count_reg);
    assign top_bwd = ring_next(1'b1, top_idx_reg, count_reg);
    assign rd_y    = rd_data_reg[2*CB-1:CB];

    // Read address select
    always_comb begin
        unique case (state_reg)
            ST_SCAN:  rd_addr = scan_idx_reg[AW-1:0];
            ST_INIT0: rd_addr = top_fwd;
            ST_INIT1: rd_addr = top_bwd;
            ST_CHECK: rd_addr = nx_idx;
            default:  rd_addr = '0;
        endcase
    end

    // Vertex memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Error accumulation and its outcomes
    assign sum       = cur.err + {2'b00, cur.run};
    assign sum_inc   = sum + (CB+2)'(1);
    assign div_start = (state_reg == ST_ACCUM) && (cur.rise != '0)
                       && (sum >= $signed({2'b00, cur.rise}));

    cpsg_div #(
        .W (DW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (sum[CB:0]),
        .divisor   ({1'b0, cur.rise}),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Position step
    always_comb begin
        if (cur.dirx > 2'sb00) begin
            mx = {{3{cur.px[CB-1]}}, cur.px} + $signed({2'b00, cnt_reg});
        end else if (cur.dirx < 2'sb00) begin
            mx = {{3{cur.px[CB-1]}}, cur.px} - $signed({2'b00, cnt_reg});
        end else begin
            mx = {{3{cur.px[CB-1]}}, cur.px};
        end
        my = {{3{cur.py[CB-1]}}, cur.py} + {{(CB+1){cur.diry[1]}}, cur.diry};
    end

    // Sequencer and next state
    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        count_next    = count_reg;
        scan_idx_next = scan_idx_reg;
        rd_vld_next   = 1'b0;
        top_idx_next  = top_idx_reg;
        min_x_next    = min_x_reg;
        min_y_next    = min_y_reg;
        wlk_next[0]   = wlk_reg[0];
        wlk_next[1]   = wlk_reg[1];
        edge_sel_next = edge_sel_reg;
        done_next     = done_reg;
        cnt_next      = cnt_reg;
        sp_y_next     = sp_y_reg;
        sp_l_next     = sp_l_reg;
        sp_r_next     = sp_r_reg;
        sp_empty_next = sp_empty_reg;
        out_load      = 1'b0;
        upd           = cur;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && !is_span) begin
                    // vertex load; a load after a closed list starts a new one
                    count_next = cnt_base + NW'(room);
                    phase_next = PH_OPEN;
                    if (s_axis_tlast) begin
                        if (count_next >= NW'(3)) begin
                            scan_idx_next = '0;
                            state_next    = ST_SCAN;
                        end else begin
                            phase_next = PH_DONE;
                        end
                    end
                end else if (accept) begin
                    done_next     = 1'b0;
                    edge_sel_next = 1'b0;
                    if (phase_reg != PH_WALK) begin
                        sp_y_next     = '0;
                        sp_l_next     = '0;
                        sp_r_next     = '0;
                        sp_empty_next = 1'b1;
                        state_next    = ST_EMIT;
                    end else begin
                        sp_y_next     = wlk_reg[0].py;
                        sp_empty_next = 1'b0;
                        if (wlk_reg[1].px < wlk_reg[0].px) begin
                            sp_l_next = wlk_reg[1].px;
                            sp_r_next = wlk_reg[0].px;
                        end else begin
                            sp_l_next = wlk_reg[0].px;
                            sp_r_next = wlk_reg[1].px;
                        end
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_SCAN: begin
                // find the first vertex with the smallest y
                rd_vld_next = scan_idx_reg < count_reg;
                if (scan_idx_reg < count_reg) begin
                    scan_idx_next = scan_idx_reg + NW'(1);
                end
                if (rd_vld_reg) begin
                    if (scan_idx_reg == NW'(1) || rd_y < min_y_reg) begin
                        top_idx_next = AW'(scan_idx_reg - NW'(1));
                        min_x_next   = rd_data_reg[CB-1:0];
                        min_y_next   = rd_y;
                    end
                    if (scan_idx_reg == count_reg) begin
                        state_next = ST_INIT0;
                    end
                end
            end

            ST_INIT0: begin
                state_next = ST_INIT1;
            end

            ST_INIT1: begin
                wlk_next[0] = aim(top_fwd, min_x_reg, min_y_reg, rd_data_reg);
                state_next  = ST_INIT2;
            end

            ST_INIT2: begin
                wlk_next[1] = aim(top_bwd, min_x_reg, min_y_reg, rd_data_reg);
                phase_next  = PH_WALK;
                state_next  = ST_IDLE;
            end

            ST_CHECK: begin
                // edge at its target row: finish or turn to the next vertex
                if (cur.py == cur.ty) begin
                    if (wlk_reg[0].ty == wlk_reg[1].ty && wlk_reg[0].tx == wlk_reg[1].tx) begin
                        done_next  = 1'b1;
                        state_next = ST_ACCUM;
                    end else begin
                        state_next = ST_FETCH;
                    end
                end else begin
                    state_next = ST_ACCUM;
                end
            end

            ST_FETCH: begin
                upd = aim(nx_idx, cur.tx, cur.ty, rd_data_reg);
                wlk_next[edge_sel_reg] = upd;
                state_next = ST_ACCUM;
            end

            ST_ACCUM: begin
                if (cur.rise != '0) begin
                    upd.err = sum;
                    cnt_next = '0;
                    if (div_start) begin
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_MOVE;
                    end
                end else if (sum >= $signed((CB+2)'(0))) begin
                    // flat edge: run plus one in a single step
                    cnt_next   = sum_inc[CB:0];
                    upd.err    = '1;
                    state_next = ST_MOVE;
                end else begin
                    upd.err    = sum;
                    cnt_next   = '0;
                    state_next = ST_MOVE;
                end
                wlk_next[edge_sel_reg] = upd;
            end

            ST_DIV: begin
                if (div_stat.done) begin
                    upd.err  = $signed({1'b0, div_rem});
                    cnt_next = div_quo;
                    wlk_next[edge_sel_reg] = upd;
                    state_next = ST_MOVE;
                end
            end

            ST_MOVE: begin
                upd.px = clamp(mx);
                upd.py = clamp(my);
                wlk_next[edge_sel_reg] = upd;
                if (!edge_sel_reg) begin
                    edge_sel_next = 1'b1;
                    state_next    = ST_CHECK;
                end else begin
                    if (done_reg) begin
                        phase_next = PH_DONE;
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!out_valid_reg || m_axis_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_OPEN;
            count_reg     <= '0;
            scan_idx_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            edge_sel_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            scan_idx_reg  <= scan_idx_next;
            rd_vld_reg    <= rd_vld_next;
            edge_sel_reg  <= edge_sel_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        top_idx_reg  <= top_idx_next;
        min_x_reg    <= min_x_next;
        min_y_reg    <= min_y_next;
        wlk_reg[0]   <= wlk_next[0];
        wlk_reg[1]   <= wlk_next[1];
        cnt_reg      <= cnt_next;
        sp_y_reg     <= sp_y_next;
        sp_l_reg     <= sp_l_next;
        sp_r_reg     <= sp_r_next;
        sp_empty_reg <= sp_empty_next;
        if (out_load) begin
            out_y_reg     <= sp_y_reg;
            out_l_reg     <= sp_l_reg;
            out_r_reg     <= sp_r_reg;
            out_last_reg  <= done_reg;
            out_empty_reg <= sp_empty_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({out_r_reg, out_l_reg, out_y_reg});
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_empty_reg;

endmodule

`default_nettype wire

FILE: verif/cpsg_tb_pkg.sv
// Command codes shared by the span generator testbench files.
package cpsg_tb_pkg;

    // tuser of the input channel
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SPAN = 1'b1;

endpackage

FILE: verif/cpsg_span_checker.sv
// Span checker: follows the polygon walk from accepted items and checks every result item.
module cpsg_span_checker
    import cpsg_pkg::*;
    import cpsg_tb_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // vertex_x, vertex_y
    input  logic        s_axis_tlast,   // last_vertex
    input  logic        s_axis_tuser,   // cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // span_y, span_left, span_right
    input  logic        m_axis_tlast,   // last_span
    input  logic        m_axis_tuser,   // empty_res
    output int          mismatch_count,
    output int          spans_outstanding
);

    typedef struct packed {
        logic signed [15:0] span_y;
        logic signed [15:0] span_left;
        logic signed [15:0] span_right;
        logic               last_span;
        logic               empty_res;
    } span_t;

    // Vertex list
    logic signed [15:0] corner_x [16];
    logic signed [15:0] corner_y [16];
    logic [4:0]         corner_cnt;
    phase_t             phase;

    // Two walking edges: 0 runs forward through the ring, 1 backward
    logic [3:0]         side_idx  [2];
    logic signed [15:0] side_tx   [2];
    logic signed [15:0] side_ty   [2];
    logic [16:0]        side_run  [2];
    logic [16:0]        side_rise [2];
    logic signed [1:0]  side_dx   [2];
    logic signed [1:0]  side_dy   [2];
    logic signed [18:0] side_err  [2];
    logic signed [15:0] side_px   [2];
    logic signed [15:0] side_py   [2];

    span_t expected_spans [$];
    int    fail_tally = 0;

    function automatic logic signed [15:0] clamp16(input longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return 16'(v);
    endfunction

    function automatic logic [3:0] ring_step(input int e, input logic [3:0] idx);
        if (e == 0) return (int'(idx) + 1 >= int'(corner_cnt)) ? 4'd0 : idx + 4'd1;
        return (idx == 4'd0) ? 4'(corner_cnt - 5'd1) : idx - 4'd1;
    endfunction

    task automatic clear_walker();
        corner_cnt = '0;
        phase = PH_OPEN;
        for (int i = 0; i < 16; i++) begin
            corner_x[i] = '0;
            corner_y[i] = '0;
        end
        for (int e = 0; e < 2; e++) begin
            side_idx[e] = '0; side_tx[e] = '0; side_ty[e] = '0;
            side_run[e] = '0; side_rise[e] = '0; side_dx[e] = '0; side_dy[e] = '0;
            side_err[e] = '0; side_px[e] = '0; side_py[e] = '0;
        end
    endtask

    // Point edge e from (fx, fy) at stored corner idx
    task automatic aim_side(input int e, input logic signed [15:0] fx,
                            input logic signed [15:0] fy, input logic [3:0] idx);
        longint dx, dy;
        side_idx[e] = idx;
        side_tx[e]  = corner_x[idx];
        side_ty[e]  = corner_y[idx];
        dx = longint'(corner_x[idx]) - longint'(fx);
        dy = longint'(corner_y[idx]) - longint'(fy);
        side_run[e]  = 17'(dx < 0 ? -dx : dx);
        side_rise[e] = 17'(dy < 0 ? -dy : dy);
        side_dx[e]   = (dx > 0) ? 2'sd1 : (dx < 0) ? -2'sd1 : 2'sd0;
        side_dy[e]   = (dy > 0) ? 2'sd1 : (dy < 0) ? -2'sd1 : 2'sd0;
        side_err[e]  = 19'(side_rise[e] >> 1);
        side_px[e]   = fx;
        side_py[e]   = fy;
    endtask

    // One row of Bresenham stepping; a flat edge jumps run + 1 at once
    task automatic step_side(input int e);
        longint err, d, cnt;
        d   = longint'(side_rise[e]);
        err = longint'(side_err[e]) + longint'(side_run[e]);
        cnt = 0;
        if (d > 0) begin
            if (err >= d) begin
                cnt = err / d;
                err = err - cnt * d;
            end
        end else if (err >= 0) begin
            cnt = err + 1;
            err = -1;
        end
        side_err[e] = 19'(err);
        side_px[e]  = clamp16(longint'(side_px[e]) + longint'(side_dx[e]) * cnt);
        side_py[e]  = clamp16(longint'(side_py[e]) + longint'(side_dy[e]));
    endtask

    task automatic start_walk();
        logic [3:0] top;
        top = 4'd0;
        for (int i = 1; i < int'(corner_cnt); i++)
            if (corner_y[i] < corner_y[top]) top = 4'(i);
        for (int e = 0; e < 2; e++)
            aim_side(e, corner_x[top], corner_y[top], ring_step(e, top));
    endtask

    // Advance the model by one accepted item
    task automatic predict_item(input logic cmd, input logic signed [15:0] vx,
                                input logic signed [15:0] vy, input logic lastv,
                                output logic produced, output span_t res);
        logic finished;
        res = '0;
        produced = 1'b0;
        if (cmd == CMD_LOAD) begin
            if (phase != PH_OPEN) begin
                corner_cnt = '0;
                phase = PH_OPEN;
            end
            if (corner_cnt < 5'd16) begin
                corner_x[corner_cnt[3:0]] = vx;
                corner_y[corner_cnt[3:0]] = vy;
                corner_cnt = corner_cnt + 5'd1;
            end
            if (lastv) begin
                if (corner_cnt >= 5'd3) begin
                    start_walk();
                    phase = PH_WALK;
                end else begin
                    phase = PH_DONE;
                end
            end
        end else begin
            produced = 1'b1;
            if (phase != PH_WALK || corner_cnt < 5'd3) begin
                res.empty_res = 1'b1;
            end else begin
                res.span_y = side_py[0];
                if (side_px[1] < side_px[0]) begin
                    res.span_left  = side_px[1];
                    res.span_right = side_px[0];
                end else begin
                    res.span_left  = side_px[0];
                    res.span_right = side_px[1];
                end
                finished = 1'b0;
                for (int e = 0; e < 2; e++) begin
                    if (side_py[e] == side_ty[e]) begin
                        if (side_ty[0] == side_ty[1] && side_tx[0] == side_tx[1])
                            finished = 1'b1;
                        else
                            aim_side(e, side_tx[e], side_ty[e], ring_step(e, side_idx[e]));
                    end
                    step_side(e);
                end
                res.last_span = finished;
                if (finished) phase = PH_DONE;
            end
        end
    endtask

    // Compare result items first, then account for the item accepted at this edge
    always @(posedge aclk) begin : watch
        span_t got, want, fresh;
        logic  produced;
        if (!aresetn) begin
            clear_walker();
            expected_spans.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.span_y     = m_axis_tdata[15:0];
                got.span_left  = m_axis_tdata[31:16];
                got.span_right = m_axis_tdata[47:32];
                got.last_span  = m_axis_tlast;
                got.empty_res  = m_axis_tuser;
                if (expected_spans.size() == 0) begin
                    fail_tally++;
                    $display("%0t: unexpected item y=%0d left=%0d right=%0d last=%0b empty=%0b",
                             $time, got.span_y, got.span_left, got.span_right,
                             got.last_span, got.empty_res);
                end else begin
                    want = expected_spans.pop_front();
                    if (got.span_y !== want.span_y || got.span_left !== want.span_left ||
                        got.span_right !== want.span_right ||
                        got.last_span !== want.last_span || got.empty_res !== want.empty_res)
                    begin
                        fail_tally++;
                        $display("%0t: expected y=%0d left=%0d right=%0d last=%0b empty=%0b",
                                 $time, want.span_y, want.span_left, want.span_right,
                                 want.last_span, want.empty_res);
                        $display("%0t:      got y=%0d left=%0d right=%0d last=%0b empty=%0b",
                                 $time, got.span_y, got.span_left, got.span_right,
                                 got.last_span, got.empty_res);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16],
                             s_axis_tlast, produced, fresh);
                if (produced) expected_spans.push_back(fresh);
            end
        end
        mismatch_count    <= fail_tally;
        spans_outstanding <= expected_spans.size();
    end

endmodule

FILE: verif/tb_convex_polygon_span_generator.sv
// Testbench top: polygon and span stimulus with random idling, plus the final verdict.
module tb_convex_polygon_span_generator;
    import cpsg_tb_pkg::*;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [31:0] s_data  = '0;    // vertex_x, vertex_y
    logic        s_last  = 1'b0;  // last_vertex
    logic        s_user  = 1'b0;  // cmd
    wire         s_ready;
    logic        m_ready = 1'b0;
    wire         m_valid;
    wire  [47:0] m_data;          // span_y, span_left, span_right
    wire         m_last;          // last_span
    wire         m_user;          // empty_res
    int          mismatch_count;
    int          spans_outstanding;

    bit quiet      = 1'b0;
    int stall_left = 0;
    int items_sent = 0;
    logic signed [15:0] poly_x [$];
    logic signed [15:0] poly_y [$];

    convex_polygon_span_generator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tlast  (s_last),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .m_axis_tuser  (m_user)
    );

    cpsg_span_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_axis_tvalid     (s_valid),
        .s_axis_tready     (s_ready),
        .s_axis_tdata      (s_data),
        .s_axis_tlast      (s_last),
        .s_axis_tuser      (s_user),
        .m_axis_tvalid     (m_valid),
        .m_axis_tready     (m_ready),
        .m_axis_tdata      (m_data),
        .m_axis_tlast      (m_last),
        .m_axis_tuser      (m_user),
        .mismatch_count    (mismatch_count),
        .spans_outstanding (spans_outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Result-side back-pressure: mostly short stalls, a few long ones
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            m_ready    <= 1'b0;
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                      : $urandom_range(0, 2);
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_item(input logic cmd, input logic signed [15:0] vx,
                             input logic signed [15:0] vy, input logic lastv);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {vy, vx};
        s_last  <= lastv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    // Span requests carry junk in the unused fields
    task automatic request_spans(input int n);
        for (int k = 0; k < n; k++)
            send_item(CMD_SPAN, 16'($urandom), 16'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Load the stored polygon, optionally from a random start and in either direction
    task automatic load_polygon(input bit shuffle);
        int  n, start, j;
        bit  backward;
        n        = poly_x.size();
        start    = shuffle ? $urandom_range(0, n - 1) : 0;
        backward = shuffle ? 1'($urandom_range(0, 1)) : 1'b0;
        for (int k = 0; k < n; k++) begin
            j = backward ? (start - k + n) % n : (start + k) % n;
            send_item(CMD_LOAD, poly_x[j], poly_y[j], k == n - 1);
        end
    endtask

    task automatic add_corner(input int x, input int y);
        poly_x.push_back(16'(x));
        poly_y.push_back(16'(y));
    endtask

    function automatic int poly_rows();
        int lo, hi;
        lo = poly_y[0];
        hi = poly_y[0];
        foreach (poly_y[i]) begin
            if (poly_y[i] < lo) lo = poly_y[i];
            if (poly_y[i] > hi) hi = poly_y[i];
        end
        return hi - lo;
    endfunction

    initial begin
        int pick, cx, cy, a, b, c, d, n, spans;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // span while the list is still open
        request_spans(1);
        // full-range triangle, walked a little, then dropped by a new list
        add_corner(-32768, -32768); add_corner(32767, -32768); add_corner(0, 32767);
        load_polygon(1'b0);
        request_spans(2);
        // two-vertex list closes without a walk
        send_item(CMD_LOAD, 16'sh7FFF, 16'sh7FFF, 1'b0);
        send_item(CMD_LOAD, 16'sh8000, 16'sh8000, 1'b1);
        request_spans(1);
        // flat bottom edge whose jump saturates, then spans after the walk ended
        poly_x.delete(); poly_y.delete();
        add_corner(0, 0); add_corner(32767, 5); add_corner(-32768, 5);
        load_polygon(1'b0);
        request_spans(7);

        while (items_sent < 1600) begin
            quiet = ($urandom_range(0, 5) == 0);
            pick  = $urandom_range(0, 99);
            cx    = $urandom_range(0, 64000) - 32000;
            cy    = $urandom_range(0, 64000) - 32000;
            poly_x.delete();
            poly_y.delete();
            if (pick < 70) begin
                a = $urandom_range(0, 15); b = $urandom_range(0, 15);
                c = $urandom_range(0, 15); d = $urandom_range(0, 15);
                case ($urandom_range(0, 2))
                    0: begin
                        for (int k = 0; k < 3; k++)
                            add_corner(cx + $urandom_range(0, 30) - 15,
                                       cy + $urandom_range(0, 30) - 15);
                    end
                    1: begin
                        add_corner(cx, cy); add_corner(cx + a, cy);
                        add_corner(cx + a, cy + b); add_corner(cx, cy + b);
                    end
                    default: begin
                        add_corner(cx, cy - a); add_corner(cx + b, cy);
                        add_corner(cx, cy + c); add_corner(cx - d, cy);
                    end
                endcase
                load_polygon(1'b1);
                spans = poly_rows() + $urandom_range(1, 3);
                if ($urandom_range(0, 7) == 0) spans = $urandom_range(0, spans);
                request_spans(spans);
            end else if (pick < 80) begin
                // arbitrary small point sets, walk may never close
                n = $urandom_range(3, 8);
                for (int k = 0; k < n; k++)
                    add_corner(cx + $urandom_range(0, 20) - 10, cy + $urandom_range(0, 20) - 10);
                load_polygon(1'b1);
                request_spans(poly_rows() + $urandom_range(0, 3));
            end else if (pick < 88) begin
                n = $urandom_range(1, 5);
                for (int k = 0; k < n; k++)
                    add_corner(int'($signed(16'($urandom))), int'($signed(16'($urandom))));
                load_polygon(1'b1);
                request_spans($urandom_range(0, 4));
            end else if (pick < 94) begin
                // more vertices than the list holds
                n = $urandom_range(17, 20);
                for (int k = 0; k < n; k++)
                    add_corner(cx + $urandom_range(0, 8) - 4, cy + $urandom_range(0, 8) - 4);
                load_polygon(1'b1);
                request_spans(poly_rows() + $urandom_range(0, 3));
            end else begin
                n = $urandom_range(1, 4);
                for (int k = 0; k < n; k++)
                    send_item(1'($urandom_range(0, 1)), 16'($urandom), 16'($urandom),
                              1'($urandom_range(0, 1)));
            end
        end

        // drain and look for stray results
        s_valid <= 1'b0;
        quiet = 1'b0;
        @(posedge aclk);
        while (spans_outstanding != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (mismatch_count == 0 && spans_outstanding == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
src/cpsg_pkg.sv
src/cpsg_div.sv
src/convex_polygon_span_generator.sv
verif/cpsg_tb_pkg.sv
verif/cpsg_span_checker.sv
verif/tb_convex_polygon_span_generator.sv
